// ===== rtl/mnde_pkg.sv =====
// Shared constants and types for the 3x3 max neighbour difference edge detector.
package mnde_pkg;

   // Configuration register file
   localparam int CSR_W       = 11;
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = CSR_INDEX_W'(1);
   localparam logic [CSR_W-1:0] CSR_SIZE_RESET = CSR_W'(512);

   // Image geometry limits
   localparam int MIN_SIZE     = 3;
   localparam int HEIGHT_LIMIT = 1024;
   localparam int ROW_W        = 10;

   // Port widths of the pixel and result fields
   localparam int PIX_IN_W = 8;
   localparam int EDGE_W   = 8;

   // Window geometry: rows held by each window column cell
   localparam int WIN_ROWS = 3;

   // Result queue depth, also the number of beats allowed in flight
   localparam int OUT_DEPTH   = 4;
   localparam int OUT_COUNT_W = $clog2(OUT_DEPTH + 1);

   // Control travelling alongside a beat through the pipeline
   typedef struct packed {
      logic valid;
      logic has_res;
      logic border;
      logic last;
   } mnde_stage_type;

endpackage

// ===== rtl/mnde_ram.sv =====
// Simple dual-port line store: one write port, one read port with registered data.
module mnde_ram #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/mnde_cell.sv =====
// One window column cell: holds three pixels and gives the largest difference to the centre.
module mnde_cell #(
   parameter int PIXEL_BITS = 8
) (
   input  logic                                          clock,
   input  logic                                          shift_en,
   input  logic [mnde_pkg::WIN_ROWS-1:0][PIXEL_BITS-1:0] col_in,
   output logic [mnde_pkg::WIN_ROWS-1:0][PIXEL_BITS-1:0] col_out,
   input  logic [PIXEL_BITS-1:0]                         centre,
   output logic [PIXEL_BITS-1:0]                         diff_max
);
   import mnde_pkg::*;

   logic [WIN_ROWS-1:0][PIXEL_BITS-1:0] col_ff;
   logic [WIN_ROWS-1:0][PIXEL_BITS-1:0] diff;

   // Take the neighbour's column on every advancing beat
   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   assign col_out = col_ff;

   // Absolute differences against the centre, then their maximum
   always_comb begin
      diff_max = '0;
      for (int r = 0; r < WIN_ROWS; r++) begin
         diff[r] = (centre > col_ff[r]) ? centre - col_ff[r] : col_ff[r] - centre;
         if (diff[r] > diff_max) begin
            diff_max = diff[r];
         end
      end
   end
endmodule

// ===== rtl/mnde_out_fifo.sv =====
// Small result queue between the window pipeline and the result channel.
module mnde_out_fifo #(
   parameter int DATA_W = 9
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic [DATA_W-1:0]                push_data,
   input  logic                             pop,
   output logic                             out_valid,
   output logic [DATA_W-1:0]                out_data,
   output logic [mnde_pkg::OUT_COUNT_W-1:0] count
);
   import mnde_pkg::*;

   localparam int PTR_W = $clog2(OUT_DEPTH);

   logic [DATA_W-1:0]      entry_ff [OUT_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [OUT_COUNT_W-1:0] count_ff, count_in;
   logic                   do_pop;

   assign do_pop = pop && (count_ff != '0);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = OUT_COUNT_W'(count_ff + 1'b1);
      end else if (!push && do_pop) begin
         count_in = OUT_COUNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed beat
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

`ifndef SYNTHESIS
   // Never push into a full queue without a pop
   assert property (@(posedge clock) disable iff (reset)
      push && !do_pop |-> count_ff < OUT_COUNT_W'(OUT_DEPTH))
      else $error("result queue overflow");

   // Occupancy never exceeds the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= OUT_COUNT_W'(OUT_DEPTH))
      else $error("result queue count beyond depth");

   // The head beat holds while it waits
   assert property (@(posedge clock) disable iff (reset)
      out_valid && !pop |=> $stable(rd_ptr_ff))
      else $error("result queue head moved without a pop");
`endif
endmodule

// ===== rtl/max_neighbour_difference_edge_3x3_top.sv =====
// Path: a result passes the s1 and s2 registers and the result queue on its way to rsp;
//    results lag the pixel stream by image_width+1 beats, flushed with drain beats.
// Throughput: one beat per cycle; req_ready drops only when four beats sit in flight or
//    in the result queue, set by the four-entry result queue.
// Reset: counters, pipeline control and queue clear; both size registers return to 512.
//    The line stores are not cleared; their stale contents reach only border pixels.
module max_neighbour_difference_edge_3x3_top #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mnde_pkg::PIX_IN_W-1:0]    req_pixel_value,
   input  logic                             req_drain,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mnde_pkg::EDGE_W-1:0]      rsp_edge_strength,
   output logic                             rsp_frame_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mnde_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mnde_pkg::CSR_W-1:0]       csr_data
);
   import mnde_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int PRIM_W = $clog2(MAX_WIDTH + 2);
   localparam int WW     = (PRIM_W > CSR_W) ? PRIM_W : CSR_W;

   // Configuration registers
   logic [CSR_W-1:0] image_width_ff, image_height_ff;
   logic             csr_write;

   // Stream counters
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [PRIM_W-1:0] priming_ff, priming_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;

   // Pipeline control and payload
   mnde_stage_type    s1_ff, s1_in, s2_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;

   logic                  accept;
   logic [WW-1:0]         w_eff, col_ext;
   logic [CSR_W-1:0]      h_eff;
   logic                  primed, row_end, frame_end;
   logic [PIXEL_BITS-1:0] pix;
   logic [PIXEL_BITS-1:0] up_rd, mid_rd;

   logic [WIN_ROWS-1:0][PIXEL_BITS-1:0] col0, col1, col2, new_col;
   logic [PIXEL_BITS-1:0] max0, max1, max2, max_all;
   logic [EDGE_W-1:0]     result;

   logic [OUT_COUNT_W-1:0] fifo_count;
   logic [OUT_COUNT_W:0]   in_flight;
   logic                   push;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign accept    = req_valid && req_ready;

   // Hold the size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= CSR_SIZE_RESET;
         image_height_ff <= CSR_SIZE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Saturate the sizes into their working ranges
   always_comb begin
      w_eff = WW'(image_width_ff);
      if (w_eff < WW'(MIN_SIZE)) begin
         w_eff = WW'(MIN_SIZE);
      end else if (w_eff > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end
      h_eff = image_height_ff;
      if (h_eff < CSR_W'(MIN_SIZE)) begin
         h_eff = CSR_W'(MIN_SIZE);
      end else if (h_eff > CSR_W'(HEIGHT_LIMIT)) begin
         h_eff = CSR_W'(HEIGHT_LIMIT);
      end
   end

   // Stream bookkeeping, decided when the beat is accepted
   always_comb begin
      col_ext   = WW'(in_col_ff);
      primed    = WW'(priming_ff) >= WW'(w_eff + 1'b1);
      row_end   = WW'(out_col_ff) + 1'b1 >= w_eff;
      frame_end = row_end && (CSR_W'(out_row_ff) + 1'b1 >= h_eff);
      pix       = req_drain ? '0 : PIXEL_BITS'(req_pixel_value);

      in_col_in  = in_col_ff;
      priming_in = priming_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;

      s1_in.valid   = accept;
      s1_in.has_res = primed;
      s1_in.border  = (out_row_ff == '0) || (CSR_W'(out_row_ff) + 1'b1 >= h_eff) ||
                      (out_col_ff == '0) || row_end;
      s1_in.last    = primed && frame_end;

      if (accept) begin
         in_col_in = (col_ext + 1'b1 >= w_eff) ? '0 : COL_W'(in_col_ff + 1'b1);
         if (!primed) begin
            priming_in = PRIM_W'(priming_ff + 1'b1);
         end else if (row_end) begin
            out_col_in = '0;
            if (!frame_end) begin
               out_row_in = ROW_W'(out_row_ff + 1'b1);
            end
         end else begin
            out_col_in = COL_W'(out_col_ff + 1'b1);
         end
         // Restart after the frame's last result
         if (primed && frame_end) begin
            in_col_in  = '0;
            priming_in = '0;
            out_col_in = '0;
            out_row_in = '0;
         end
      end
      // A write to either size register restarts the frame
      if (csr_write && (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT)) begin
         in_col_in  = '0;
         priming_in = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   // Hold counters and pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         priming_ff <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         s1_ff      <= '0;
         s2_ff      <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         priming_ff <= priming_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         s1_ff      <= s1_in;
         s2_ff      <= s1_ff;
      end
   end

   // Beat payload for the store update stage
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff <= in_col_ff;
         s1_pix_ff <= pix;
      end
   end

   // Line stores: read on accept, move the column up one row in the following cycle
   mnde_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PIXEL_BITS)
   ) u_upper_store (
      .clock   (clock),
      .wr_en   (s1_ff.valid),
      .wr_addr (s1_col_ff),
      .wr_data (mid_rd),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .rd_data (up_rd)
   );

   mnde_ram #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PIXEL_BITS)
   ) u_middle_store (
      .clock   (clock),
      .wr_en   (s1_ff.valid),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (in_col_ff),
      .rd_data (mid_rd)
   );

   // Window: three column cells, the newest column enters the first cell
   assign new_col = {s1_pix_ff, mid_rd, up_rd};

   mnde_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell_right (
      .clock    (clock),
      .shift_en (s1_ff.valid),
      .col_in   (new_col),
      .col_out  (col0),
      .centre   (col1[1]),
      .diff_max (max0)
   );

   mnde_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell_centre (
      .clock    (clock),
      .shift_en (s1_ff.valid),
      .col_in   (col0),
      .col_out  (col1),
      .centre   (col1[1]),
      .diff_max (max1)
   );

   mnde_cell #(.PIXEL_BITS(PIXEL_BITS)) u_cell_left (
      .clock    (clock),
      .shift_en (s1_ff.valid),
      .col_in   (col1),
      .col_out  (col2),
      .centre   (col1[1]),
      .diff_max (max2)
   );

   // Combine the cell maxima; border pixels give zero
   always_comb begin
      max_all = (max0 > max1) ? max0 : max1;
      if (max2 > max_all) begin
         max_all = max2;
      end
      result = s2_ff.border ? '0 : EDGE_W'(max_all);
   end

   // Queue finished results
   assign push = s2_ff.valid && s2_ff.has_res;

   mnde_out_fifo #(.DATA_W(EDGE_W + 1)) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({result, s2_ff.last}),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  ({rsp_edge_strength, rsp_frame_last}),
      .count     (fifo_count)
   );

   // Accept while the queue can absorb every beat already in flight
   assign in_flight = (OUT_COUNT_W + 1)'(fifo_count) + (OUT_COUNT_W + 1)'(s1_ff.valid) +
                      (OUT_COUNT_W + 1)'(s2_ff.valid);
   assign req_ready = in_flight < (OUT_COUNT_W + 1)'(OUT_DEPTH);

`ifndef SYNTHESIS
   // A finished result always finds room in the queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> fifo_count < OUT_COUNT_W'(OUT_DEPTH))
      else $error("result pushed into full queue");

   // The input column stays inside the row
   assert property (@(posedge clock) disable iff (reset)
      WW'(in_col_ff) < w_eff)
      else $error("input column beyond image width");

   // The frame's last result restarts all counters
   assert property (@(posedge clock) disable iff (reset)
      accept && primed && frame_end |=>
         in_col_ff == '0 && priming_ff == '0 && out_col_ff == '0 && out_row_ff == '0)
      else $error("counters not cleared after frame end");

   // The output column stays inside the row
   assert property (@(posedge clock) disable iff (reset)
      WW'(out_col_ff) < w_eff)
      else $error("output column beyond image width");
`endif
endmodule

// ===== verif/max_neighbour_difference_edge_3x3_top_test.sv =====
// Self-checking testbench for the 3x3 max neighbour difference edge detector top level.
`timescale 1ns / 100ps

module max_neighbour_difference_edge_3x3_top_test;
   import mnde_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 8;
   localparam int LINE_DEPTH    = 1024;
   localparam int COL_W         = $clog2(LINE_DEPTH);
   localparam int WIN_COLS      = 3;
   localparam int STALL_LIMIT   = 5000;
   localparam int LONG_HOLD     = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 20;
   localparam int PHASE_BEATS   = 150;
   localparam int OPENING_BEATS = 560;
   localparam int REPORT_LIMIT  = 10;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = CSR_INDEX_W'(15);
   localparam logic [PIX_IN_W-1:0]    PIX_MAX    = '1;

   typedef enum int {
      FRAME_CLEAN,
      FRAME_SCATTER,
      FRAME_RAGGED,
      FRAME_ABORT
   } frame_kind_type;

   typedef struct {
      logic [PIX_IN_W-1:0] pixel;
      logic                drain;
   } pixel_beat_type;

   typedef struct {
      logic [EDGE_W-1:0] strength;
      logic              last;
   } edge_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [PIX_IN_W-1:0]    req_pixel_value = '0;
   logic                   req_drain = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [EDGE_W-1:0]      rsp_edge_strength;
   logic                   rsp_frame_last;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]       csr_data = '0;

   // Edge detector model state
   logic [PIX_IN_W-1:0] upper_line [LINE_DEPTH];
   logic [PIX_IN_W-1:0] middle_line [LINE_DEPTH];
   logic [PIX_IN_W-1:0] window [WIN_ROWS][WIN_COLS];
   logic [COL_W-1:0]    in_col;
   logic [10:0]         in_row;
   logic [COL_W-1:0]    out_col;
   logic [ROW_W-1:0]    out_row;
   logic [10:0]         prime_count;
   logic [CSR_W-1:0]    cfg_width;
   logic [CSR_W-1:0]    cfg_height;

   pixel_beat_type  pixel_q [$];
   edge_result_type edge_expect_q [$];

   int beats_queued    = 0;
   int beats_accepted  = 0;
   int results_checked = 0;
   int frames_seen     = 0;
   int csr_writes      = 0;
   int error_count     = 0;
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   bit hold_armed = 1'b0;
   bit hold_done  = 1'b0;
   int hold_left  = 0;
   int idle_cycles = 0;

   max_neighbour_difference_edge_3x3_top #(
      .MAX_WIDTH (LINE_DEPTH),
      .PIXEL_BITS(PIX_IN_W)
   ) dut (.*);

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int clamp_size(input logic [CSR_W-1:0] value, input int upper);
      int s;
      s = int'(value);
      if (s < MIN_SIZE) s = MIN_SIZE;
      if (s > upper) s = upper;
      return s;
   endfunction

   function automatic void restart_edge_model();
      int r, k;
      for (r = 0; r < WIN_ROWS; r++)
         for (k = 0; k < WIN_COLS; k++)
            window[r][k] = '0;
      in_col      = '0;
      in_row      = '0;
      out_col     = '0;
      out_row     = '0;
      prime_count = '0;
   endfunction

   // Advance the model by one beat and queue the result it gives, if any
   function automatic void step_edge_model(input logic [PIX_IN_W-1:0] pixel_in,
                                           input logic drain_in);
      int w, h, col, r, k;
      logic [PIX_IN_W-1:0] pix, up, mid, diff;
      edge_result_type res;
      w   = clamp_size(cfg_width, LINE_DEPTH);
      h   = clamp_size(cfg_height, HEIGHT_LIMIT);
      pix = drain_in ? '0 : pixel_in;
      col = int'(in_col);

      // move the column up one row in the line stores, shift it into the window
      up  = upper_line[col];
      mid = middle_line[col];
      upper_line[col]  = mid;
      middle_line[col] = pix;
      for (r = 0; r < WIN_ROWS; r++) begin
         window[r][0] = window[r][1];
         window[r][1] = window[r][2];
      end
      window[0][2] = up;
      window[1][2] = mid;
      window[2][2] = pix;

      if (col + 1 >= w) begin
         in_col = '0;
         in_row = in_row + 1'b1;
      end else begin
         in_col = COL_W'(col + 1);
      end

      // the first row plus one pixel of a frame only primes the window
      if (int'(prime_count) < w + 1) begin
         prime_count = prime_count + 1'b1;
      end else begin
         res.strength = '0;
         res.last     = 1'b0;
         if (out_row != 0 && int'(out_row) + 1 < h && out_col != 0 && int'(out_col) + 1 < w) begin
            for (r = 0; r < WIN_ROWS; r++)
               for (k = 0; k < WIN_COLS; k++) begin
                  diff = (window[1][1] > window[r][k]) ? window[1][1] - window[r][k]
                                                       : window[r][k] - window[1][1];
                  if (diff > res.strength) res.strength = diff;
               end
         end
         if (int'(out_col) + 1 >= w) begin
            out_col = '0;
            if (int'(out_row) + 1 >= h) res.last = 1'b1;
            else out_row = out_row + 1'b1;
         end else begin
            out_col = out_col + 1'b1;
         end
         edge_expect_q.push_back(res);
         if (res.last) restart_edge_model();
      end
   endfunction

   function automatic void note_failure(input string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("ERROR at %0t ns: %s", $time, what);
   endfunction

   function automatic logic [PIX_IN_W-1:0] pick_pixel();
      case ($urandom_range(3))
         0:       return '0;
         1:       return PIX_MAX;
         default: return PIX_IN_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_beat(input logic [PIX_IN_W-1:0] pixel, input logic drain);
      pixel_beat_type b;
      b.pixel = pixel;
      b.drain = drain;
      pixel_q.push_back(b);
      beats_queued++;
   endtask

   // Hold off until every beat is in and every result is out, then let the pipe settle
   task automatic wait_for_idle();
      while (pixel_q.size() != 0 || req_valid || edge_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [CSR_W-1:0] data);
      wait_for_idle();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      csr_writes++;
      if (index == CSR_IMAGE_WIDTH) begin
         cfg_width = data;
         restart_edge_model();
      end else if (index == CSR_IMAGE_HEIGHT) begin
         cfg_height = data;
         restart_edge_model();
      end
   endtask

   // Queue one frame of the current geometry, well formed or deliberately broken
   task automatic queue_frame(input frame_kind_type kind);
      int w, h, pixels, drains, total, i;
      w      = clamp_size(cfg_width, LINE_DEPTH);
      h      = clamp_size(cfg_height, HEIGHT_LIMIT);
      pixels = w * h;
      drains = w + 1;
      if (kind == FRAME_RAGGED) begin
         drains = $urandom_range(0, 2 * w + 2);
      end else if (kind == FRAME_ABORT) begin
         total  = $urandom_range(1, pixels + w);
         drains = (total > pixels) ? total - pixels : 0;
         pixels = total - drains;
      end
      for (i = 0; i < pixels; i++)
         queue_beat(pick_pixel(), kind == FRAME_SCATTER && $urandom_range(7) == 0);
      for (i = 0; i < drains; i++)
         queue_beat(PIX_IN_W'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic pick_geometry();
      logic [CSR_W-1:0] w, h;
      case ($urandom_range(9))
         0:       w = CSR_W'($urandom_range(0, 2));
         1:       w = CSR_W'($urandom_range(13, 40));
         default: w = CSR_W'($urandom_range(3, 12));
      endcase
      case ($urandom_range(9))
         0:       h = CSR_W'($urandom_range(0, 2));
         1:       h = CSR_W'($urandom_range(9, 16));
         default: h = CSR_W'($urandom_range(3, 8));
      endcase
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
   endtask

   // Driver: offer the oldest pending beat, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            void'(pixel_q.pop_front());
            step_edge_model(req_pixel_value, req_drain);
            beats_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid       <= 1'b1;
               req_pixel_value <= pixel_q[0].pixel;
               req_drain       <= pixel_q[0].drain;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result beat against the oldest expectation
   always @(posedge clock) begin
      edge_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (edge_expect_q.size() == 0) begin
               note_failure($sformatf("unexpected result edge=%0d last=%0d",
                                      rsp_edge_strength, rsp_frame_last));
            end else begin
               want = edge_expect_q.pop_front();
               results_checked++;
               if (rsp_edge_strength !== want.strength || rsp_frame_last !== want.last)
                  note_failure($sformatf("result %0d: expected edge=%0d last=%0d, got edge=%0d last=%0d",
                                         results_checked, want.strength, want.last,
                                         rsp_edge_strength, rsp_frame_last));
               if (want.last) frames_seen++;
            end
         end
         // one long hold-off so the block backs up onto its input
         if (hold_armed && !hold_done) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Watchdog: end the run when no channel has moved a beat for too long
   initial begin
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("max_neighbour_difference_edge_3x3_top test failed");
      $finish;
   end

   // Stimulus
   initial begin
      int i, phase, phase_start, pick;
      frame_kind_type kind;

      cfg_width  = CSR_SIZE_RESET;
      cfg_height = CSR_SIZE_RESET;
      foreach (upper_line[j]) begin
         upper_line[j]  = '0;
         middle_line[j] = '0;
      end
      restart_edge_model();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // part of a frame at the reset sizes, then cut short by a register write
      for (i = 0; i < OPENING_BEATS; i++) queue_beat(PIX_IN_W'($urandom_range(0, 255)), 1'b0);

      // smallest frame: dark centre in a bright ring, then bright centre in a dark ring
      write_csr(CSR_IMAGE_WIDTH, CSR_W'(MIN_SIZE));
      write_csr(CSR_IMAGE_HEIGHT, CSR_W'(MIN_SIZE));
      for (i = 0; i < 9; i++) queue_beat((i == 4) ? '0 : PIX_MAX, 1'b0);
      for (i = 0; i < 4; i++) queue_beat('0, 1'b1);
      // drain beats inside the frame stand for dark pixels whatever they carry
      for (i = 0; i < 9; i++)
         if (i == 0 || i == 7) queue_beat(PIX_MAX, 1'b1);
         else queue_beat((i == 4) ? PIX_MAX : '0, 1'b0);
      for (i = 0; i < 4; i++) queue_beat(PIX_MAX, 1'b1);

      // a write to an unused index must leave the sizes alone
      write_csr(CSR_UNUSED, '1);
      queue_frame(FRAME_CLEAN);

      // smallest frame again, reached through register values below the range
      write_csr(CSR_IMAGE_WIDTH, CSR_W'(1));
      write_csr(CSR_IMAGE_HEIGHT, '0);
      queue_frame(FRAME_CLEAN);

      // receiver holds off while the sender keeps offering
      write_csr(CSR_IMAGE_WIDTH, CSR_W'(10));
      write_csr(CSR_IMAGE_HEIGHT, CSR_W'(6));
      hold_armed = 1'b1;
      queue_frame(FRAME_CLEAN);

      // random frames under each idling pattern
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1:       begin sender_idle_pct = 87; receiver_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  receiver_stall_pct = 87; end
            default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
         endcase
         phase_start = beats_queued;
         pick_geometry();
         while (beats_queued - phase_start < PHASE_BEATS) begin
            if ($urandom_range(2) == 0) pick_geometry();
            pick = $urandom_range(19);
            kind = (pick < 15) ? FRAME_CLEAN :
                   (pick < 17) ? FRAME_SCATTER :
                   (pick < 19) ? FRAME_RAGGED : FRAME_ABORT;
            queue_frame(kind);
            if (kind == FRAME_ABORT) pick_geometry();
         end
      end

      wait_for_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (edge_expect_q.size() != 0)
         note_failure($sformatf("%0d expected results never arrived", edge_expect_q.size()));

      $display("Run covered %0d input beats, %0d checked results and %0d whole frames",
               beats_accepted, results_checked, frames_seen);
      $display("with %0d register writes, widths from 3 to 512, drains and cut frames; %0d errors",
               csr_writes, error_count);
      if (error_count == 0)
         $display("max_neighbour_difference_edge_3x3_top test passed");
      else
         $display("max_neighbour_difference_edge_3x3_top test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/mnde_pkg.sv
rtl/mnde_ram.sv
rtl/mnde_cell.sv
rtl/mnde_out_fifo.sv
rtl/max_neighbour_difference_edge_3x3_top.sv
verif/max_neighbour_difference_edge_3x3_top_test.sv
